@@ sv/fic_pkg.sv @@
// Shared types and field widths for the Fenwick inversion counter.
// Used by the top level and by whoever instantiates its channels; no dependencies.
package fic_pkg;

	localparam int VALUE_W   = 8;
	localparam int SMALLER_W = 13;
	localparam int TOTAL_W   = 23;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               start_req;
	} item_t;

	typedef struct packed {
		logic [SMALLER_W-1:0] smaller_seen;
		logic [TOTAL_W-1:0]   inversion_total;
		logic                 overflow;
	} result_t;

endpackage

@@ sv/fic_chan_if.sv @@
// Valid/ready channel carrying one payload beat per handshake.
// The payload type is a parameter; fic_pkg supplies the item and result types.
interface fic_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

@@ sv/fic_cell.sv @@
// One level of the Fenwick tree: holds every counter whose lowest set index bit is LEVEL.
// A token passing through either adds the stored count to its sum or bumps the counter.
// No package dependencies.
module fic_cell #(
	parameter int VALUE_BITS = 8,
	parameter int LEVEL      = 0,
	parameter int CNT_BITS   = 13,
	parameter int CLR_BITS   = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clr_en,
	input  logic [CLR_BITS-1:0]   clr_addr,
	input  logic                  in_valid,
	input  logic [VALUE_BITS-1:0] in_value,
	input  logic [CNT_BITS-1:0]   in_acc,
	output logic                  out_valid,
	output logic [VALUE_BITS-1:0] out_value,
	output logic [CNT_BITS-1:0]   out_acc
);

	localparam int ADDR_BITS = VALUE_BITS - LEVEL - 1;

	logic                  tok_valid_s1;
	logic [VALUE_BITS-1:0] tok_v_s1;
	logic [CNT_BITS-1:0]   tok_acc_s1;
	logic [CNT_BITS-1:0]   rdata_q;
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] out_value_q;
	logic [CNT_BITS-1:0]   out_acc_q;
	logic                  wr_en;
	logic [CNT_BITS-1:0]   wr_data;

	// A clear bit at this level means the recorded value falls under this counter's range;
	// a set bit means the whole range lies below the value being queried.
	assign wr_en   = clr_en | (tok_valid_s1 & ~tok_v_s1[LEVEL]);
	assign wr_data = clr_en ? '0 : rdata_q + {{(CNT_BITS-1){1'b0}}, 1'b1};

	if (ADDR_BITS > 0) begin : g_mem
		localparam int DEPTH = 1 << ADDR_BITS;
		logic [CNT_BITS-1:0]  mem [DEPTH];
		logic [ADDR_BITS-1:0] rd_addr;
		logic [ADDR_BITS-1:0] wr_addr;

		assign rd_addr = in_value[VALUE_BITS-1:LEVEL+1];
		assign wr_addr = clr_en ? clr_addr[ADDR_BITS-1:0] : tok_v_s1[VALUE_BITS-1:LEVEL+1];

		always_ff @(posedge clk) begin
			if (wr_en) begin
				mem[wr_addr] <= wr_data;
			end
			if (in_valid) begin
				rdata_q <= mem[rd_addr];
			end
		end
	end else begin : g_reg
		logic [CNT_BITS-1:0] cnt_q;

		always_ff @(posedge clk) begin
			if (wr_en) begin
				cnt_q <= wr_data;
			end
			if (in_valid) begin
				rdata_q <= cnt_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_valid_s1 <= 1'b0;
			tok_v_s1     <= '0;
			tok_acc_s1   <= '0;
			out_valid_q  <= 1'b0;
			out_value_q  <= '0;
			out_acc_q    <= '0;
		end else begin
			tok_valid_s1 <= in_valid;
			if (in_valid) begin
				tok_v_s1   <= in_value;
				tok_acc_s1 <= in_acc;
			end
			out_valid_q <= tok_valid_s1;
			if (tok_valid_s1) begin
				out_value_q <= tok_v_s1;
				out_acc_q   <= tok_v_s1[LEVEL] ? tok_acc_s1 + rdata_q : tok_acc_s1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_acc   = out_acc_q;

	a_no_token_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> !clr_en)
		else $error("token reached a cell during the clearing sweep");

	a_single_token: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid_s1 |-> !in_valid)
		else $error("second token entered a cell still busy with one");

	a_token_forwarded: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid_s1 |=> out_valid && out_value == $past(tok_v_s1))
		else $error("token not passed on with its value");

endmodule

@@ sv/fenwick_inversion_counter_unit.sv @@
// Inversion counter over a binary indexed tree of 2^VALUE_BITS value slots, built as a chain
// of VALUE_BITS cells, one per tree level, each holding its level's counters in a small RAM
// (a register in the top cell). An item walks the chain once, each cell doing a RAM read,
// then an add or increment; an item past MAX_LEN skips the chain and goes straight to its
// result beat. The tree is cleared by a sweep over the 2^(VALUE_BITS-1) addresses (128 by
// default) of the deepest cell RAM, after reset and before any item that carries start_req.
// One item is in flight at a time; the next is taken while a finished result still waits
// in the output register.
module fenwick_inversion_counter_unit #(
	parameter int VALUE_BITS = 8,
	parameter int MAX_LEN    = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	fic_chan_if.sink    item,
	fic_chan_if.source  result
);

	localparam int CNT_BITS = $clog2(MAX_LEN + 1);
	localparam int CLR_BITS = (VALUE_BITS > 1) ? VALUE_BITS - 1 : 1;
	localparam logic [CLR_BITS-1:0] CLR_LAST = CLR_BITS'((1 << (VALUE_BITS - 1)) - 1);
	localparam logic [CNT_BITS-1:0] MAX_CNT  = CNT_BITS'(MAX_LEN);

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_RUN, S_HOLD} state_t;

	state_t                          state_q;
	logic [CLR_BITS-1:0]             clr_cnt_q;
	logic                            pend_q;
	logic                            launch_q;
	logic [VALUE_BITS-1:0]           launch_v_q;
	logic [CNT_BITS-1:0]             items_q;
	logic [fic_pkg::TOTAL_W-1:0]     total_q;
	logic [fic_pkg::SMALLER_W-1:0]   res_smaller_q;
	logic                            res_ovf_q;
	logic                            out_valid_q;
	fic_pkg::result_t                out_q;

	logic [VALUE_BITS-1:0]           v_in;
	logic                            link_valid [VALUE_BITS+1];
	logic [VALUE_BITS-1:0]           link_v     [VALUE_BITS+1];
	logic [CNT_BITS-1:0]             link_acc   [VALUE_BITS+1];
	logic [CNT_BITS+fic_pkg::TOTAL_W-1:0]   acc_total_wide;
	logic [CNT_BITS+fic_pkg::SMALLER_W-1:0] acc_smaller_wide;

	// Only the low VALUE_BITS bits of the value select a slot.
	for (genvar i = 0; i < VALUE_BITS; i++) begin : g_vbit
		if (i < fic_pkg::VALUE_W) begin : g_in
			assign v_in[i] = item.payload.value[i];
		end else begin : g_zero
			assign v_in[i] = 1'b0;
		end
	end

	assign link_valid[0] = launch_q;
	assign link_v[0]     = launch_v_q;
	assign link_acc[0]   = '0;

	for (genvar k = 0; k < VALUE_BITS; k++) begin : g_cell
		fic_cell #(
			.VALUE_BITS(VALUE_BITS),
			.LEVEL     (k),
			.CNT_BITS  (CNT_BITS),
			.CLR_BITS  (CLR_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.clr_en   (state_q == S_CLEAR),
			.clr_addr (clr_cnt_q),
			.in_valid (link_valid[k]),
			.in_value (link_v[k]),
			.in_acc   (link_acc[k]),
			.out_valid(link_valid[k+1]),
			.out_value(link_v[k+1]),
			.out_acc  (link_acc[k+1])
		);
	end

	assign acc_total_wide   = {{fic_pkg::TOTAL_W{1'b0}}, link_acc[VALUE_BITS]};
	assign acc_smaller_wide = {{fic_pkg::SMALLER_W{1'b0}}, link_acc[VALUE_BITS]};

	assign item.ready     = (state_q == S_IDLE);
	assign result.valid   = out_valid_q;
	assign result.payload = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_cnt_q     <= '0;
			pend_q        <= 1'b0;
			launch_q      <= 1'b0;
			launch_v_q    <= '0;
			items_q       <= '0;
			total_q       <= '0;
			res_smaller_q <= '0;
			res_ovf_q     <= 1'b0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
		end else begin
			launch_q <= 1'b0;
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + {{(CLR_BITS-1){1'b0}}, 1'b1};
					if (clr_cnt_q == CLR_LAST) begin
						clr_cnt_q <= '0;
						if (pend_q) begin
							pend_q   <= 1'b0;
							launch_q <= 1'b1;
							state_q  <= S_RUN;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_IDLE: begin
					if (item.valid) begin
						launch_v_q <= v_in;
						if (item.payload.start_req) begin
							items_q <= '0;
							total_q <= '0;
							pend_q  <= 1'b1;
							state_q <= S_CLEAR;
						end else if (items_q == MAX_CNT) begin
							res_smaller_q <= '0;
							res_ovf_q     <= 1'b1;
							state_q       <= S_HOLD;
						end else begin
							launch_q <= 1'b1;
							state_q  <= S_RUN;
						end
					end
				end
				S_RUN: begin
					if (link_valid[VALUE_BITS]) begin
						res_smaller_q <= acc_smaller_wide[fic_pkg::SMALLER_W-1:0];
						res_ovf_q     <= 1'b0;
						total_q       <= total_q + acc_total_wide[fic_pkg::TOTAL_W-1:0];
						items_q       <= items_q + {{(CNT_BITS-1){1'b0}}, 1'b1};
						state_q       <= S_HOLD;
					end
				end
				S_HOLD: begin
					// The output register frees up in the same beat that it is taken.
					if (!out_valid_q || result.ready) begin
						out_valid_q           <= 1'b1;
						out_q.smaller_seen    <= res_smaller_q;
						out_q.inversion_total <= total_q;
						out_q.overflow        <= res_ovf_q;
						state_q               <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	a_run_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (items_q < MAX_CNT))
		else $error("item walked the tree after the length limit was reached");

	a_chain_only_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		link_valid[VALUE_BITS] |-> (state_q == S_RUN))
		else $error("chain delivered a token outside the run state");

	a_overflow_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.payload.overflow) |-> (result.payload.smaller_seen == '0))
		else $error("overflowed result carries a non-zero count");

endmodule

@@ test/fic_inversion_checker.sv @@
// Checker for the Fenwick inversion counter: watches the item and result channels,
// keeps its own tally of each sequence and compares every result beat in order.
// Depends on fic_pkg for the beat types and field widths.
module fic_inversion_checker #(
	parameter int MAX_LEN = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  logic             item_ready,
	input  fic_pkg::item_t   item_payload,
	input  logic             result_valid,
	input  logic             result_ready,
	input  fic_pkg::result_t result_payload,
	output int               errors,
	output int               pending
);

	localparam int VALUE_W   = fic_pkg::VALUE_W;
	localparam int SMALLER_W = fic_pkg::SMALLER_W;
	localparam int TOTAL_W   = fic_pkg::TOTAL_W;
	localparam int SLOTS     = 1 << VALUE_W;

	int unsigned        value_histogram [SLOTS];
	int unsigned        seq_length;
	logic [TOTAL_W-1:0] inversion_sum;
	fic_pkg::result_t   due_tallies [$];

	initial errors = 0;

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		errors++;
	endtask

	function automatic void clear_sequence();
		foreach (value_histogram[i]) value_histogram[i] = 0;
		seq_length    = 0;
		inversion_sum = '0;
	endfunction

	// Counts earlier values of the sequence below this one, then records it.
	function automatic fic_pkg::result_t tally_item(input fic_pkg::item_t beat);
		fic_pkg::result_t tally;
		int unsigned      below;
		logic             past_end;
		if (beat.start_req)
			clear_sequence();
		below    = 0;
		past_end = (seq_length >= MAX_LEN);
		if (!past_end) begin
			for (int v = 0; v < int'(beat.value); v++)
				below += value_histogram[v];
			inversion_sum += TOTAL_W'(below);
			value_histogram[beat.value]++;
			seq_length++;
		end
		tally.smaller_seen    = SMALLER_W'(below);
		tally.inversion_total = inversion_sum;
		tally.overflow        = past_end;
		return tally;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		fic_pkg::result_t want;
		if (!arst_n) begin
			clear_sequence();
			due_tallies.delete();
			pending <= 0;
		end else begin
			// Results are checked before the item of the same edge is tallied,
			// so a beat can never be matched against its own item.
			if (result_valid && result_ready) begin
				if (due_tallies.size() == 0) begin
					report_mismatch("result beat arrived with nothing outstanding");
				end else begin
					want = due_tallies.pop_front();
					if (result_payload.smaller_seen !== want.smaller_seen)
						report_mismatch($sformatf("smaller_seen %0d, expected %0d",
							result_payload.smaller_seen, want.smaller_seen));
					if (result_payload.inversion_total !== want.inversion_total)
						report_mismatch($sformatf("inversion_total %0d, expected %0d",
							result_payload.inversion_total, want.inversion_total));
					if (result_payload.overflow !== want.overflow)
						report_mismatch($sformatf("overflow %0b, expected %0b",
							result_payload.overflow, want.overflow));
				end
			end
			if (item_valid && item_ready)
				due_tallies.push_back(tally_item(item_payload));
			pending <= due_tallies.size();
		end
	end

endmodule

@@ test/tb_fenwick_inversion_counter_unit.sv @@
// Top of the inversion counter testbench: clock, reset, item stimulus and result back-pressure.
// Instantiates fenwick_inversion_counter_unit beside fic_inversion_checker, which does the
// comparison; depends on fic_pkg and fic_chan_if.
module tb_fenwick_inversion_counter_unit;

	localparam int VALUE_W      = fic_pkg::VALUE_W;
	localparam int MAX_LEN      = 4096;
	localparam int RAMP_LEN     = 600;
	localparam int STALL_LIMIT  = 3000;
	localparam int DRAIN_CYCLES = 64;

	logic clk = 1'b0;
	logic arst_n;
	int   send_idle_pct;
	int   recv_stall_pct;
	int   quiet_cycles;
	int   error_count;
	int   pending_count;

	fic_chan_if #(.payload_t(fic_pkg::item_t))   item_ch ();
	fic_chan_if #(.payload_t(fic_pkg::result_t)) result_ch ();

	fenwick_inversion_counter_unit #(
		.VALUE_BITS(VALUE_W),
		.MAX_LEN   (MAX_LEN)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch),
		.result(result_ch)
	);

	fic_inversion_checker #(
		.MAX_LEN(MAX_LEN)
	) i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_ch.valid),
		.item_ready    (item_ch.ready),
		.item_payload  (item_ch.payload),
		.result_valid  (result_ch.valid),
		.result_ready  (result_ch.ready),
		.result_payload(result_ch.payload),
		.errors        (error_count),
		.pending       (pending_count)
	);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(99, 0) >= recv_stall_pct);
	end

	// Ends the run if neither channel moves a beat for too long.
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Valid stays high from one beat to the next unless an idle cycle is drawn,
	// so it is never lowered and raised within the same step.
	task automatic push_item(input logic [VALUE_W-1:0] value, input logic start);
		fic_pkg::item_t beat;
		beat.value     = value;
		beat.start_req = start;
		while ($urandom_range(99, 0) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid   <= 1'b1;
		item_ch.payload <= beat;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	task automatic hold_until_drained();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct, input int budget);
		int sent;
		int len;
		int lo;
		int hi;
		logic start;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		sent           = 0;
		while (sent < budget) begin
			len = ($urandom_range(9, 0) == 0) ? $urandom_range(200, 41) : $urandom_range(40, 1);
			// A quarter of the sequences crowd into a few values to force many ties.
			if ($urandom_range(3, 0) == 0) begin
				lo = $urandom_range(252, 0);
				hi = lo + 3;
			end else begin
				lo = 0;
				hi = 255;
			end
			// Now and then a sequence carries on from the previous one.
			start = ($urandom_range(7, 0) != 0);
			for (int k = 0; k < len; k++)
				push_item(VALUE_W'($urandom_range(hi, lo)), (k == 0) && start);
			sent += len;
			if ($urandom_range(19, 0) == 0)
				hold_until_drained();
		end
		hold_until_drained();
	endtask

	initial begin
		int ramp;
		arst_n          = 1'b0;
		item_ch.valid   = 1'b0;
		item_ch.payload = '0;
		result_ch.ready = 1'b0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// The first beat relies on the clearing after reset alone.
		push_item(8'd5, 1'b0);
		push_item(8'd0, 1'b0);
		push_item(8'd255, 1'b0);
		push_item(8'd255, 1'b0);
		push_item(8'd0, 1'b1);
		push_item(8'd0, 1'b0);
		push_item(8'd255, 1'b0);
		push_item(8'd128, 1'b0);
		push_item(8'd127, 1'b0);
		push_item(8'd129, 1'b0);
		push_item(8'd1, 1'b0);
		push_item(8'd254, 1'b0);
		push_item(8'd170, 1'b1);
		push_item(8'd85, 1'b0);
		push_item(8'd170, 1'b0);
		push_item(8'd171, 1'b0);
		push_item(8'd200, 1'b1);
		push_item(8'd100, 1'b1);
		push_item(8'd50, 1'b1);
		push_item(8'd255, 1'b1);
		push_item(8'd254, 1'b0);
		push_item(8'd253, 1'b0);
		push_item(8'd0, 1'b0);
		hold_until_drained();

		// One long sequence on a rising ramp with small jitter, which lifts the total
		// well above the width of the per-item count.
		push_item(8'd0, 1'b1);
		for (int k = 1; k < RAMP_LEN; k++) begin
			ramp = (k * 2) / 5 + $urandom_range(2, 0);
			if (ramp > 255)
				ramp = 255;
			push_item(VALUE_W'(ramp), 1'b0);
		end
		hold_until_drained();

		run_phase(0, 0, 300);
		run_phase(86, 0, 300);
		run_phase(0, 86, 300);
		run_phase(13, 13, 300);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0 && pending_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
sv/fic_pkg.sv
sv/fic_chan_if.sv
sv/fic_cell.sv
sv/fenwick_inversion_counter_unit.sv
test/fic_inversion_checker.sv
test/tb_fenwick_inversion_counter_unit.sv
